// ===== hw/rtl/tpp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpp_pkg: shared definitions of the three-axis PID to PWM unit
// Widths, register indexes, controller states and constants used by the
// top level and by its serial arithmetic units.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // Axis storage.
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam int ACC_W  = 48;

    // Controller datapath widths.
    localparam int ANGLE_W = 16;
    localparam int ERR_W   = 18;
    localparam int DIFF_W  = 19;
    localparam int RATE_W  = 20;
    localparam int SUM_W   = 66;
    localparam int SPD_W   = 9;

    // Angles above thirty degrees (Q8.8) are taken as thirty degrees.
    localparam logic signed [ANGLE_W-1:0] ANGLE_CEIL = 16'sd7680;

    // Serial multiplier: one four-bit digit of the second operand a cycle.
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 32;
    localparam int MUL_DIG_W = 4;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIG_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // Integral term limit, far beyond any threshold.
    localparam logic [MUL_P_W-1:0] TERM_LIMIT = 80'd1 << 62;

    // Serial divider: one quotient bit a cycle.
    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT0 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT1 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT2 = 4'd7;

    // Controller sequence.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_INT_GO,
        ST_INT_WAIT,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_P_GO,
        ST_P_WAIT,
        ST_D_GO,
        ST_D_WAIT,
        ST_I_GO,
        ST_I_WAIT,
        ST_CLIP,
        ST_SCL_GO,
        ST_SCL_WAIT,
        ST_QUO_GO,
        ST_QUO_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/tpp_mul.sv =====
// ----------------------------------------------------------------------------
// tpp_mul: digit-serial unsigned multiplier
// Shifts the second operand out one four-bit digit a cycle and adds the
// matching partial product into the upper half of the product register.
// ----------------------------------------------------------------------------
module tpp_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tpp_pkg::MUL_A_W-1:0]    a,
    input  logic [tpp_pkg::MUL_B_W-1:0]    b,
    output logic                           done,
    output logic [tpp_pkg::MUL_P_W-1:0]    product
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tpp_pkg::MUL_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tpp_pkg::MUL_A_W-1:0]       a_reg, a_next;
    logic [tpp_pkg::MUL_A_W-1:0]       hi_reg, hi_next;
    logic [tpp_pkg::MUL_B_W-1:0]       lo_reg, lo_next;
    logic [tpp_pkg::MUL_A_W+tpp_pkg::MUL_DIG_W-1:0] step;

    // One digit step: add the partial product, then shift the pair right.
    always_comb begin
        step = {{tpp_pkg::MUL_DIG_W{1'b0}}, hi_reg}
             + ((tpp_pkg::MUL_A_W+tpp_pkg::MUL_DIG_W)'(a_reg)
                * (tpp_pkg::MUL_A_W+tpp_pkg::MUL_DIG_W)'(lo_reg[tpp_pkg::MUL_DIG_W-1:0]));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end else if (busy_reg) begin
            hi_next  = step[tpp_pkg::MUL_A_W+tpp_pkg::MUL_DIG_W-1:tpp_pkg::MUL_DIG_W];
            lo_next  = {step[tpp_pkg::MUL_DIG_W-1:0],
                        lo_reg[tpp_pkg::MUL_B_W-1:tpp_pkg::MUL_DIG_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tpp_pkg::MUL_CNT_W'(tpp_pkg::MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; operands are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hw/rtl/tpp_div.sv =====
// ----------------------------------------------------------------------------
// tpp_div: bit-serial unsigned restoring divider
// Shifts the dividend in one bit a cycle and develops one quotient bit per
// cycle in the same shift register.
// ----------------------------------------------------------------------------
module tpp_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tpp_pkg::DIV_N_W-1:0]    dividend,
    input  logic [tpp_pkg::DIV_D_W-1:0]    divisor,
    output logic                           done,
    output logic [tpp_pkg::DIV_N_W-1:0]    quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tpp_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tpp_pkg::DIV_D_W-1:0]       den_reg, den_next;
    logic [tpp_pkg::DIV_D_W-1:0]       rem_reg, rem_next;
    logic [tpp_pkg::DIV_N_W-1:0]       quo_reg, quo_next;
    logic [tpp_pkg::DIV_D_W:0]         shifted;
    logic [tpp_pkg::DIV_D_W+1:0]       trial;

    // One restoring step per cycle.
    always_comb begin
        shifted   = {rem_reg, quo_reg[tpp_pkg::DIV_N_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial[tpp_pkg::DIV_D_W+1]) begin
                rem_next = shifted[tpp_pkg::DIV_D_W-1:0];
                quo_next = {quo_reg[tpp_pkg::DIV_N_W-2:0], 1'b0};
            end else begin
                rem_next = trial[tpp_pkg::DIV_D_W-1:0];
                quo_next = {quo_reg[tpp_pkg::DIV_N_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tpp_pkg::DIV_CNT_W'(tpp_pkg::DIV_N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/three_axis_pid_to_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_to_pwm_unit: three-axis PID regulator with PWM scaling
// Per-axis PID on angle samples, scaled and clipped to a signed drive value.
// ----------------------------------------------------------------------------
// The unit handles one sample at a time. A sample for a valid axis places its
// result in the output register, and the next sample can be taken in the cycle
// after that. Each of the five products on the shared four-bit digit-serial
// multiplier takes 8 digit steps with a start and a finish around them, each of
// the up to two quotients on the shared bit-serial divider takes 40 bit steps
// with a start and a finish around them, and the rest goes to sequencing. A
// sample that clips skips the scaling product and quotient, and one with zero
// elapsed time skips the rate quotient. A sample with an axis of three or more
// goes straight to the output state and gives a zero result. The next sample is
// taken as soon as the result has been placed in the output register, even while
// that result is still waiting; a result that is still waiting when the next one
// is ready holds the unit until m_tready.
// ----------------------------------------------------------------------------
module three_axis_pid_to_pwm_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input: tdata = angle [15:0], time_ms [47:16]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Input: tuser = axis [1:0]
    input  logic [1:0]  s_tuser,
    // Output: tdata = motor_speed [8:0], saturated [9], zero [15:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic signed [51:0] ACC_MAX = (52'sd1 <<< (tpp_pkg::ACC_W - 1)) - 52'sd1;
    localparam logic signed [51:0] ACC_MIN = -(52'sd1 <<< (tpp_pkg::ACC_W - 1));

    tpp_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0]                         gain_p_reg, gain_i_reg, gain_d_reg;
    logic [31:0]                         thr_reg;
    logic [7:0]                          max_pwm_reg;
    logic signed [tpp_pkg::ANGLE_W-1:0]  setpoint_reg [tpp_pkg::AXES];

    // Per-axis state.
    logic signed [tpp_pkg::ACC_W-1:0]    integ_mem_reg [tpp_pkg::AXES];
    logic signed [tpp_pkg::ERR_W-1:0]    perr_mem_reg  [tpp_pkg::AXES];
    logic [31:0]                         ptime_mem_reg [tpp_pkg::AXES];

    // Working registers of the current sample.
    logic [tpp_pkg::AXIS_W-1:0]          axis_reg;
    logic                                axis_ok_reg;
    logic signed [tpp_pkg::ANGLE_W-1:0]  angle_reg;
    logic [31:0]                         time_reg;
    logic signed [tpp_pkg::ERR_W-1:0]    err_reg;
    logic signed [tpp_pkg::DIFF_W-1:0]   diff_reg;
    logic [31:0]                         elapsed_reg;
    logic signed [tpp_pkg::ACC_W-1:0]    integ_reg;
    logic signed [tpp_pkg::RATE_W-1:0]   rate_reg;
    logic signed [tpp_pkg::SUM_W-1:0]    sum_reg;
    logic [tpp_pkg::DIV_N_W-1:0]         scaled_reg;
    logic signed [tpp_pkg::SPD_W-1:0]    spd_reg;
    logic                                sat_reg;

    // Output register.
    logic                                m_valid_reg;
    logic signed [tpp_pkg::SPD_W-1:0]    m_spd_reg;
    logic                                m_sat_reg;

    // Arithmetic unit connections.
    logic                                mul_start, mul_done;
    logic [tpp_pkg::MUL_A_W-1:0]         mul_a;
    logic [tpp_pkg::MUL_B_W-1:0]         mul_b;
    logic [tpp_pkg::MUL_P_W-1:0]         mul_p;
    logic                                div_start, div_done;
    logic [tpp_pkg::DIV_N_W-1:0]         div_n;
    logic [tpp_pkg::DIV_D_W-1:0]         div_d;
    logic [tpp_pkg::DIV_N_W-1:0]         div_q;

    // Derived values.
    logic                                s_accept, out_free;
    logic signed [tpp_pkg::ANGLE_W-1:0]  in_angle, in_angle_clamped;
    logic                                in_axis_ok;
    logic signed [tpp_pkg::ERR_W-1:0]    err_c;
    logic [tpp_pkg::ERR_W-1:0]           err_mag;
    logic [tpp_pkg::DIFF_W-1:0]          diff_mag;
    logic [tpp_pkg::RATE_W-1:0]          rate_mag;
    logic [tpp_pkg::ACC_W-1:0]           integ_mag;
    logic [tpp_pkg::SUM_W-1:0]           sum_mag;
    logic signed [50:0]                  int_add;
    logic signed [51:0]                  int_tot;
    logic [tpp_pkg::MUL_P_W-1:0]         i_lim;
    logic [tpp_pkg::SUM_W-1:0]           term_mag;
    logic                                term_neg;
    logic signed [tpp_pkg::SUM_W-1:0]    term_s;
    logic signed [tpp_pkg::SUM_W-1:0]    thr_s, nthr_s;
    logic                                in_scale;
    logic signed [tpp_pkg::SPD_W-1:0]    max_s;

    tpp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    tpp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // Handshakes.
    assign s_tready  = (state_reg == tpp_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, m_sat_reg, m_spd_reg};

    // Input decode and magnitudes of the signed working values.
    always_comb begin
        in_angle         = s_tdata[15:0];
        in_angle_clamped = (in_angle > tpp_pkg::ANGLE_CEIL) ? tpp_pkg::ANGLE_CEIL : in_angle;
        in_axis_ok       = ({1'b0, s_tuser} < 3'(tpp_pkg::AXES));
        err_c     = tpp_pkg::ERR_W'(setpoint_reg[axis_reg]) - tpp_pkg::ERR_W'(angle_reg);
        err_mag   = err_reg[tpp_pkg::ERR_W-1] ? tpp_pkg::ERR_W'(-err_reg)
                                              : tpp_pkg::ERR_W'(err_reg);
        diff_mag  = diff_reg[tpp_pkg::DIFF_W-1] ? tpp_pkg::DIFF_W'(-diff_reg)
                                                : tpp_pkg::DIFF_W'(diff_reg);
        rate_mag  = rate_reg[tpp_pkg::RATE_W-1] ? tpp_pkg::RATE_W'(-rate_reg)
                                                : tpp_pkg::RATE_W'(rate_reg);
        integ_mag = integ_reg[tpp_pkg::ACC_W-1] ? tpp_pkg::ACC_W'(-integ_reg)
                                                : tpp_pkg::ACC_W'(integ_reg);
        sum_mag   = sum_reg[tpp_pkg::SUM_W-1] ? tpp_pkg::SUM_W'(-sum_reg)
                                              : tpp_pkg::SUM_W'(sum_reg);
    end

    // Saturating integral update from the error times elapsed time.
    always_comb begin
        int_add = err_reg[tpp_pkg::ERR_W-1] ? -$signed({1'b0, mul_p[49:0]})
                                            : $signed({1'b0, mul_p[49:0]});
        int_tot = 52'(integ_reg) + 52'(int_add);
    end

    // Signed gain term added to the controller sum.
    always_comb begin
        i_lim = (mul_p > tpp_pkg::TERM_LIMIT) ? tpp_pkg::TERM_LIMIT : mul_p;
        case (state_reg)
            tpp_pkg::ST_I_WAIT: begin
                term_mag = tpp_pkg::SUM_W'(i_lim);
                term_neg = integ_reg[tpp_pkg::ACC_W-1];
            end
            tpp_pkg::ST_D_WAIT: begin
                term_mag = tpp_pkg::SUM_W'(mul_p);
                term_neg = rate_reg[tpp_pkg::RATE_W-1];
            end
            default: begin
                term_mag = tpp_pkg::SUM_W'(mul_p);
                term_neg = err_reg[tpp_pkg::ERR_W-1];
            end
        endcase
        term_s = term_neg ? -$signed(term_mag) : $signed(term_mag);
    end

    // Range test against the full-scale threshold.
    always_comb begin
        thr_s    = $signed({34'd0, thr_reg});
        nthr_s   = -thr_s;
        in_scale = (!sum_reg[tpp_pkg::SUM_W-1] && (sum_reg < thr_s))
                || (sum_reg[tpp_pkg::SUM_W-1] && (sum_reg >= nthr_s));
        max_s    = $signed({1'b0, max_pwm_reg});
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tpp_pkg::ST_IDLE:
                if (s_accept) begin
                    state_next = in_axis_ok ? tpp_pkg::ST_PREP : tpp_pkg::ST_OUT;
                end
            tpp_pkg::ST_PREP:      state_next = tpp_pkg::ST_INT_GO;
            tpp_pkg::ST_INT_GO:    state_next = tpp_pkg::ST_INT_WAIT;
            tpp_pkg::ST_INT_WAIT:
                if (mul_done) begin
                    state_next = tpp_pkg::ST_RATE_GO;
                end
            tpp_pkg::ST_RATE_GO:
                state_next = (elapsed_reg == 32'd0) ? tpp_pkg::ST_P_GO : tpp_pkg::ST_RATE_WAIT;
            tpp_pkg::ST_RATE_WAIT:
                if (div_done) begin
                    state_next = tpp_pkg::ST_P_GO;
                end
            tpp_pkg::ST_P_GO:      state_next = tpp_pkg::ST_P_WAIT;
            tpp_pkg::ST_P_WAIT:
                if (mul_done) begin
                    state_next = tpp_pkg::ST_D_GO;
                end
            tpp_pkg::ST_D_GO:      state_next = tpp_pkg::ST_D_WAIT;
            tpp_pkg::ST_D_WAIT:
                if (mul_done) begin
                    state_next = tpp_pkg::ST_I_GO;
                end
            tpp_pkg::ST_I_GO:      state_next = tpp_pkg::ST_I_WAIT;
            tpp_pkg::ST_I_WAIT:
                if (mul_done) begin
                    state_next = tpp_pkg::ST_CLIP;
                end
            tpp_pkg::ST_CLIP:
                state_next = in_scale ? tpp_pkg::ST_SCL_GO : tpp_pkg::ST_OUT;
            tpp_pkg::ST_SCL_GO:    state_next = tpp_pkg::ST_SCL_WAIT;
            tpp_pkg::ST_SCL_WAIT:
                if (mul_done) begin
                    state_next = tpp_pkg::ST_QUO_GO;
                end
            tpp_pkg::ST_QUO_GO:    state_next = tpp_pkg::ST_QUO_WAIT;
            tpp_pkg::ST_QUO_WAIT:
                if (div_done) begin
                    state_next = tpp_pkg::ST_OUT;
                end
            tpp_pkg::ST_OUT:
                if (out_free) begin
                    state_next = tpp_pkg::ST_IDLE;
                end
            default:               state_next = tpp_pkg::ST_IDLE;
        endcase
    end

    // Unit starts and operand selection.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        unique case (state_reg)
            tpp_pkg::ST_INT_GO: begin
                mul_start = 1'b1;
                mul_a     = tpp_pkg::MUL_A_W'(err_mag);
                mul_b     = elapsed_reg;
            end
            tpp_pkg::ST_RATE_GO: begin
                div_start = (elapsed_reg != 32'd0);
                div_n     = tpp_pkg::DIV_N_W'(diff_mag);
                div_d     = elapsed_reg;
            end
            tpp_pkg::ST_P_GO: begin
                mul_start = 1'b1;
                mul_a     = tpp_pkg::MUL_A_W'(err_mag);
                mul_b     = tpp_pkg::MUL_B_W'(gain_p_reg);
            end
            tpp_pkg::ST_D_GO: begin
                mul_start = 1'b1;
                mul_a     = tpp_pkg::MUL_A_W'(rate_mag);
                mul_b     = tpp_pkg::MUL_B_W'(gain_d_reg);
            end
            tpp_pkg::ST_I_GO: begin
                mul_start = 1'b1;
                mul_a     = integ_mag;
                mul_b     = tpp_pkg::MUL_B_W'(gain_i_reg);
            end
            tpp_pkg::ST_SCL_GO: begin
                mul_start = 1'b1;
                mul_a     = tpp_pkg::MUL_A_W'(sum_mag[31:0]);
                mul_b     = tpp_pkg::MUL_B_W'(max_pwm_reg);
            end
            tpp_pkg::ST_QUO_GO: begin
                div_start = 1'b1;
                div_n     = scaled_reg;
                div_d     = thr_reg;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // State register, configuration and per-axis state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            gain_p_reg  <= 16'd256;
            gain_i_reg  <= 16'd0;
            gain_d_reg  <= 16'd0;
            thr_reg     <= 32'd65536;
            max_pwm_reg <= 8'd255;
            for (int k = 0; k < tpp_pkg::AXES; k++) begin
                setpoint_reg[k]  <= '0;
                integ_mem_reg[k] <= '0;
                perr_mem_reg[k]  <= '0;
                ptime_mem_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    tpp_pkg::CFG_GAIN_P:    gain_p_reg      <= cfg_data[15:0];
                    tpp_pkg::CFG_GAIN_I:    gain_i_reg      <= cfg_data[15:0];
                    tpp_pkg::CFG_GAIN_D:    gain_d_reg      <= cfg_data[15:0];
                    tpp_pkg::CFG_THRESHOLD: thr_reg         <= cfg_data;
                    tpp_pkg::CFG_MAX_PWM:   max_pwm_reg     <= cfg_data[7:0];
                    tpp_pkg::CFG_SETPOINT0: setpoint_reg[0] <= cfg_data[15:0];
                    tpp_pkg::CFG_SETPOINT1: setpoint_reg[1] <= cfg_data[15:0];
                    tpp_pkg::CFG_SETPOINT2: setpoint_reg[2] <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // The output register empties on a transaction and refills at the end of a sample.
            if (state_reg == tpp_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                if (axis_ok_reg) begin
                    integ_mem_reg[axis_reg] <= integ_reg;
                    perr_mem_reg[axis_reg]  <= err_reg;
                    ptime_mem_reg[axis_reg] <= time_reg;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath of the current sample.
    always_ff @(posedge aclk) begin
        case (state_reg)
            tpp_pkg::ST_IDLE:
                if (s_accept) begin
                    axis_reg    <= s_tuser;
                    axis_ok_reg <= in_axis_ok;
                    angle_reg   <= in_angle_clamped;
                    time_reg    <= s_tdata[47:16];
                    spd_reg     <= '0;
                    sat_reg     <= 1'b0;
                end
            tpp_pkg::ST_PREP: begin
                err_reg     <= err_c;
                diff_reg    <= tpp_pkg::DIFF_W'(err_c) - tpp_pkg::DIFF_W'(perr_mem_reg[axis_reg]);
                elapsed_reg <= time_reg - ptime_mem_reg[axis_reg];
                integ_reg   <= integ_mem_reg[axis_reg];
                sum_reg     <= '0;
            end
            tpp_pkg::ST_INT_WAIT:
                if (mul_done) begin
                    if (int_tot > ACC_MAX) begin
                        integ_reg <= tpp_pkg::ACC_W'(ACC_MAX);
                    end else if (int_tot < ACC_MIN) begin
                        integ_reg <= tpp_pkg::ACC_W'(ACC_MIN);
                    end else begin
                        integ_reg <= tpp_pkg::ACC_W'(int_tot);
                    end
                end
            tpp_pkg::ST_RATE_GO:
                rate_reg <= '0;
            tpp_pkg::ST_RATE_WAIT:
                if (div_done) begin
                    rate_reg <= diff_reg[tpp_pkg::DIFF_W-1]
                              ? -$signed(tpp_pkg::RATE_W'(div_q))
                              : $signed(tpp_pkg::RATE_W'(div_q));
                end
            tpp_pkg::ST_P_WAIT, tpp_pkg::ST_D_WAIT, tpp_pkg::ST_I_WAIT:
                if (mul_done) begin
                    sum_reg <= sum_reg + term_s;
                end
            tpp_pkg::ST_CLIP:
                if (!in_scale) begin
                    sat_reg <= 1'b1;
                    spd_reg <= (sum_reg < nthr_s) ? -max_s : max_s;
                end
            tpp_pkg::ST_SCL_WAIT:
                if (mul_done) begin
                    scaled_reg <= mul_p[tpp_pkg::DIV_N_W-1:0];
                end
            tpp_pkg::ST_QUO_WAIT:
                if (div_done) begin
                    spd_reg <= sum_reg[tpp_pkg::SUM_W-1]
                             ? -$signed(tpp_pkg::SPD_W'(div_q))
                             : $signed(tpp_pkg::SPD_W'(div_q));
                end
            tpp_pkg::ST_OUT:
                if (out_free) begin
                    m_spd_reg <= spd_reg;
                    m_sat_reg <= sat_reg;
                end
            default: ;
        endcase
    end

endmodule

// ===== tb/pid_pwm_checker.sv =====
// ----------------------------------------------------------------------------
// pid_pwm_checker: drive value checker for the three-axis PID to PWM unit
// Watches the sample, result and register channels, keeps its own copy of
// the per-axis controller state and compares every result with a prediction.
// ----------------------------------------------------------------------------
module pid_pwm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [8:0] speed;
        logic              sat;
    } drive_t;

    localparam longint ACC_MAX = (64'sd1 <<< (tpp_pkg::ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint TERM_MAX = 64'sd1 <<< 62;

    // Register copy.
    logic [15:0] kp, ki, kd;
    logic [31:0] full_scale;
    logic [7:0]  pwm_max;
    logic signed [15:0] target [3];

    // Per-axis controller state.
    longint      integ [tpp_pkg::AXES];
    longint      last_err [tpp_pkg::AXES];
    logic [31:0] last_ms [tpp_pkg::AXES];

    drive_t expected_drive [$];

    // Predict one drive value and advance the axis state.
    function automatic drive_t predict_drive(logic [1:0] ax, logic signed [15:0] ang,
                                             logic [31:0] now);
        drive_t d;
        longint a, err, dt, rate, sum, thr, mag, ti, acc, pm;
        logic [31:0] el;
        d = '0;
        if (ax >= tpp_pkg::AXES) return d;
        a = ang;
        if (a > 7680) a = 7680;
        el = now - last_ms[ax];
        dt = el;
        err = longint'(target[ax]) - a;
        acc = integ[ax];
        if (err * dt > 0 && acc > ACC_MAX - err * dt) acc = ACC_MAX;
        else if (err * dt < 0 && acc < ACC_MIN - err * dt) acc = ACC_MIN;
        else acc = acc + err * dt;
        integ[ax] = acc;
        rate = (dt == 0) ? 0 : (err - last_err[ax]) / dt;
        sum = longint'(kp) * err + longint'(kd) * rate;
        // The integral product is limited so it always clips.
        mag = acc < 0 ? -acc : acc;
        if (ki == 0) ti = 0;
        else if (mag > TERM_MAX / longint'(ki)) ti = TERM_MAX;
        else ti = mag * longint'(ki);
        sum += acc < 0 ? -ti : ti;
        thr = full_scale;
        pm = longint'(pwm_max);
        if (sum >= 0 && sum < thr) d.speed = 9'(sum * pm / thr);
        else if (sum < 0 && sum >= -thr) d.speed = 9'(sum * pm / thr);
        else if (sum < -thr) begin
            d.speed = -9'(pwm_max);
            d.sat = 1'b1;
        end else begin
            d.speed = 9'(pwm_max);
            d.sat = 1'b1;
        end
        last_err[ax] = err;
        last_ms[ax] = now;
        return d;
    endfunction

    assign pending = expected_drive.size();

    // Follow every transaction on the three channels.
    always @(posedge aclk) begin
        drive_t got, want;
        if (!aresetn) begin
            kp <= 16'd256; ki <= '0; kd <= '0;
            full_scale <= 32'd65536; pwm_max <= 8'd255;
            for (int k = 0; k < 3; k++) target[k] <= '0;
            for (int k = 0; k < tpp_pkg::AXES; k++) begin
                integ[k] = 0; last_err[k] = 0; last_ms[k] = '0;
            end
            expected_drive.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tpp_pkg::CFG_GAIN_P:    kp <= cfg_data[15:0];
                    tpp_pkg::CFG_GAIN_I:    ki <= cfg_data[15:0];
                    tpp_pkg::CFG_GAIN_D:    kd <= cfg_data[15:0];
                    tpp_pkg::CFG_THRESHOLD: full_scale <= cfg_data;
                    tpp_pkg::CFG_MAX_PWM:   pwm_max <= cfg_data[7:0];
                    tpp_pkg::CFG_SETPOINT0: target[0] <= cfg_data[15:0];
                    tpp_pkg::CFG_SETPOINT1: target[1] <= cfg_data[15:0];
                    tpp_pkg::CFG_SETPOINT2: target[2] <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_drive.push_back(predict_drive(s_tuser, s_tdata[15:0],
                                                       s_tdata[47:16]));
            if (m_tvalid && m_tready) begin
                got.speed = m_tdata[8:0];
                got.sat = m_tdata[9];
                if (expected_drive.size() == 0) begin
                    $display("%0t: unexpected result %0d/%0d", $time, got.speed, got.sat);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_drive.pop_front();
                    if (got.speed !== want.speed) begin
                        $display("%0t: speed expected %0d actual %0d", $time,
                                 want.speed, got.speed);
                        fail_count <= fail_count + 1;
                    end else if (got.sat !== want.sat || m_tdata[15:10] !== '0) begin
                        $display("%0t: saturated/pad expected %0b actual %0b/%h", $time,
                                 want.sat, got.sat, m_tdata[15:10]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the three-axis PID to PWM unit
// Directed edge samples, then random per-axis sample sequences under several
// register settings, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready, m_tvalid, m_tready = 1'b0;
    logic [47:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic [15:0] m_tdata;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count, pending;
    int cycles = 0;
    bit calm = 1'b0;
    logic [31:0] clock_ms [3];

    localparam int CYCLE_LIMIT = 1500000;

    three_axis_pid_to_pwm_unit dut (.*);
    pid_pwm_checker checker_i (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cycle counter guards against a hang.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side accepts in random stall bursts.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // The valid line drops at the accepting edge and the task returns at the edge after it.
    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [1:0] ax, logic [15:0] ang, logic [31:0] ms);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            repeat (n) @(posedge aclk);
        end
        s_tuser <= ax; s_tdata <= {ms, ang}; s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_settings(int mode);
        logic [31:0] thr;
        case (mode)
            0: thr = 32'd1;
            1: thr = 32'hFFFF_FFFF;
            default: thr = $urandom_range(1, 1 << 22);
        endcase
        write_reg(tpp_pkg::CFG_GAIN_P, mode == 1 ? 32'hFFFF : $urandom_range(0, 1024));
        write_reg(tpp_pkg::CFG_GAIN_I, mode == 0 ? 32'd0 : $urandom_range(0, 3) == 0 ?
                  32'hFFFF : $urandom_range(0, 16));
        write_reg(tpp_pkg::CFG_GAIN_D, mode == 1 ? 32'hFFFF : $urandom_range(0, 2048));
        write_reg(tpp_pkg::CFG_THRESHOLD, thr);
        write_reg(tpp_pkg::CFG_MAX_PWM, mode == 0 ? 32'd0 : mode == 1 ? 32'd255 :
                  $urandom_range(0, 255));
        write_reg(tpp_pkg::CFG_SETPOINT0, $urandom);
        write_reg(tpp_pkg::CFG_SETPOINT1, mode == 1 ? 32'h8000 : $urandom_range(0, 4000));
        write_reg(tpp_pkg::CFG_SETPOINT2, mode == 1 ? 32'h7FFF :
                  $urandom_range(0, 8000) - 4000);
    endtask

    initial begin
        logic [1:0] ax;
        logic [15:0] ang;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: angle extremes, ceiling, zero elapsed time, bad axis, time wrap.
        send_sample(2'd0, 16'h7FFF, 32'd0);
        send_sample(2'd0, 16'd7680, 32'd0);
        send_sample(2'd0, 16'd7681, 32'd5);
        send_sample(2'd1, 16'h8000, 32'hFFFF_FFFF);
        send_sample(2'd1, 16'h0000, 32'd3);
        send_sample(2'd3, 16'h1234, 32'd77);
        send_sample(2'd2, 16'hFF00, 32'd1);
        drain();
        write_reg(4'd9, 32'hFFFF_FFFF);
        write_reg(tpp_pkg::CFG_GAIN_I, 32'hFFFF);
        write_reg(tpp_pkg::CFG_GAIN_D, 32'hFFFF);
        write_reg(tpp_pkg::CFG_THRESHOLD, 32'd256);
        write_reg(tpp_pkg::CFG_SETPOINT0, 32'h7FFF);
        send_sample(2'd0, 16'h8000, 32'hFFFF_FFFF);
        send_sample(2'd0, 16'h8000, 32'hFFFF_FFFE);
        send_sample(2'd0, 16'h8000, 32'h7FFF_FFFF);
        send_sample(2'd2, 16'h0001, 32'd2);
        send_sample(2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        drain();
        // Sum equal to minus the threshold: kp=256, error -1 gives -256.
        write_reg(tpp_pkg::CFG_GAIN_I, 32'd0);
        write_reg(tpp_pkg::CFG_GAIN_D, 32'd0);
        write_reg(tpp_pkg::CFG_GAIN_P, 32'd256);
        write_reg(tpp_pkg::CFG_MAX_PWM, 32'd200);
        send_sample(2'd1, 16'd1, 32'd10);
        send_sample(2'd1, 16'hFFFF, 32'd10);
        drain();

        // Random phases: monotonic time per axis with occasional jumps and repeats.
        for (int ph = 0; ph < 9; ph++) begin
            random_settings(ph);
            if (ph == 8) calm = 1'b1;
            for (int k = 0; k < 3; k++) clock_ms[k] = $urandom;
            for (int i = 0; i < 100; i++) begin
                ax = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
                ang = $urandom_range(0, 7) == 0 ? 16'($urandom) :
                      16'($urandom_range(0, 16000) - 8000);
                case ($urandom_range(0, 9))
                    0: ;
                    1: clock_ms[ax % 3] = $urandom;
                    default: clock_ms[ax % 3] += $urandom_range(1, 40);
                endcase
                send_sample(ax, ang, clock_ms[ax % 3]);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/tpp_pkg.sv
hw/rtl/tpp_mul.sv
hw/rtl/tpp_div.sv
hw/rtl/three_axis_pid_to_pwm_unit.sv
tb/pid_pwm_checker.sv
tb/tb.sv
